[hw/rtl/kwm_pkg.sv]
// ----------------------------------------------------------------------------
// kwm_pkg
// Types, constants and helpers shared by the k-way merge heap.
// ----------------------------------------------------------------------------
package kwm_pkg;

   localparam int MAX_RUNS = 16;
   localparam int KEY_BITS = 32;

   localparam int IDX_W    = $clog2(MAX_RUNS);
   localparam int CNT_W    = $clog2(MAX_RUNS + 1);
   localparam int CHD_W    = IDX_W + 2;

   localparam int CMD_W    = 2;
   localparam int RUN_W    = 4;
   localparam int IO_KEY_W = 32;
   localparam int ROW_W    = 32;
   localparam int NUM_W    = 5;

   localparam logic [NUM_W-1:0] NUM_RUNS_RST = NUM_W'(16);

   typedef enum logic [CMD_W-1:0] {
      CMD_START = 2'd0,
      CMD_PUSH  = 2'd1,
      CMD_END   = 2'd2
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_UP_CMP,
      ST_UP_FIN,
      ST_POP_CHK,
      ST_POP_ROOT,
      ST_POP_LAST,
      ST_DN_CHK,
      ST_DN_RDR,
      ST_DN_CMP
   } state_type;

   typedef struct packed {
      logic signed [KEY_BITS-1:0] key;
      logic [ROW_W-1:0]           row;
      logic [RUN_W-1:0]           run;
   } rec_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
      rec_type          data;
   } ram_wr_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] addr;
   } ram_rd_type;

   typedef struct packed {
      logic    load;
      rec_type rec;
   } pop_type;

   // Ascending by signed key, equal keys by ascending row id.
   function automatic logic rec_less(rec_type a, rec_type b);
      logic res;
      if (a.key != b.key) begin
         res = ($signed(a.key) < $signed(b.key));
      end else begin
         res = (a.row < b.row);
      end
      return res;
   endfunction

   function automatic logic [KEY_BITS-1:0] norm_key(logic [IO_KEY_W-1:0] k);
      logic [IO_KEY_W+KEY_BITS-1:0] wide;
      wide = {{KEY_BITS{k[IO_KEY_W-1]}}, k};
      return wide[KEY_BITS-1:0];
   endfunction

   function automatic logic [IO_KEY_W-1:0] out_key_of(logic [KEY_BITS-1:0] k);
      logic [IO_KEY_W+KEY_BITS-1:0] wide;
      wide = {{IO_KEY_W{k[KEY_BITS-1]}}, k};
      return wide[IO_KEY_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] parent_of(logic [IDX_W-1:0] i);
      return IDX_W'((i - 1'b1) >> 1);
   endfunction

endpackage

[hw/rtl/kwm_req_if.sv]
// ----------------------------------------------------------------------------
// kwm_req_if
// Command channel into the merge heap: start, push and run-end commands.
// ----------------------------------------------------------------------------
interface kwm_req_if
   import kwm_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [RUN_W-1:0]    run;
   logic [IO_KEY_W-1:0] key;
   logic [ROW_W-1:0]    row_id;

   modport source (output valid, cmd, run, key, row_id, input ready);
   modport sink   (input valid, cmd, run, key, row_id, output ready);
endinterface

[hw/rtl/kwm_rsp_if.sv]
// ----------------------------------------------------------------------------
// kwm_rsp_if
// Result channel out of the merge heap: popped record and its run.
// ----------------------------------------------------------------------------
interface kwm_rsp_if
   import kwm_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [IO_KEY_W-1:0] out_key;
   logic [ROW_W-1:0]    out_row_id;
   logic [RUN_W-1:0]    refill_run;

   modport source (output valid, out_key, out_row_id, refill_run, input ready);
   modport sink   (input valid, out_key, out_row_id, refill_run, output ready);
endinterface

[hw/rtl/kwm_heap_ram.sv]
// ----------------------------------------------------------------------------
// kwm_heap_ram
// Heap record store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kwm_heap_ram
   import kwm_pkg::*;
(
   input  logic       clock,
   input  ram_wr_type wr,
   input  ram_rd_type rd,
   output rec_type    rd_data
);

   rec_type mem [MAX_RUNS];
   rec_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
      if (rd.en) begin
         rd_data_ff <= mem[rd.addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[hw/rtl/kwm_ctrl.sv]
// ----------------------------------------------------------------------------
// kwm_ctrl
// Command decode and heap sequencer: sift-up on push, sift-down on pop.
// ----------------------------------------------------------------------------
module kwm_ctrl
   import kwm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [NUM_W-1:0] num_runs,
   kwm_req_if.sink          req,
   input  logic             rsp_free,
   output ram_wr_type       ram_wr,
   output ram_rd_type       ram_rd,
   input  rec_type          ram_q,
   output pop_type          pop
);

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] size_ff, size_in;
   logic [CNT_W-1:0] active_ff, active_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   rec_type          rec_ff, rec_in;
   rec_type          child_ff, child_in;

   rec_type          in_rec;
   logic [IDX_W-1:0] in_idx;
   logic [IDX_W-1:0] par;
   logic [CHD_W-1:0] lft, rgt, size_x;
   logic             pop_need;
   logic             l_less;
   rec_type          best;
   logic [CHD_W-1:0] best_idx;

   assign in_rec.key = norm_key(req.key);
   assign in_rec.row = req.row_id;
   assign in_rec.run = req.run;
   assign in_idx     = size_ff[IDX_W-1:0];

   assign par      = parent_of(idx_ff);
   assign lft      = {1'b0, idx_ff, 1'b1};
   assign rgt      = lft + 1'b1;
   assign size_x   = CHD_W'(size_ff);
   assign pop_need = (size_ff != '0) && (size_ff >= active_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         size_ff   <= '0;
         active_ff <= '0;
      end else begin
         state_ff  <= state_in;
         size_ff   <= size_in;
         active_ff <= active_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      rec_ff   <= rec_in;
      child_ff <= child_in;
   end

   always_comb begin
      state_in     = state_ff;
      size_in      = size_ff;
      active_in    = active_ff;
      idx_in       = idx_ff;
      rec_in       = rec_ff;
      child_in     = child_ff;
      ram_wr       = '0;
      ram_rd       = '0;
      pop.load     = 1'b0;
      pop.rec      = ram_q;
      req.ready    = 1'b0;
      l_less       = 1'b0;
      best         = rec_ff;
      best_idx     = CHD_W'(idx_ff);

      unique case (state_ff)
         ST_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               unique case (req.cmd)
                  CMD_START: begin
                     size_in = '0;
                     if (int'(num_runs) > MAX_RUNS) begin
                        active_in = CNT_W'(MAX_RUNS);
                     end else begin
                        active_in = CNT_W'(num_runs);
                     end
                  end
                  CMD_PUSH: begin
                     if ((active_ff != '0) && (size_ff < active_ff)
                         && (int'(size_ff) < MAX_RUNS)) begin
                        size_in = size_ff + 1'b1;
                        rec_in  = in_rec;
                        idx_in  = in_idx;
                        if (in_idx == '0) begin
                           ram_wr   = '{en: 1'b1, addr: '0, data: in_rec};
                           state_in = ST_POP_CHK;
                        end else begin
                           ram_rd   = '{en: 1'b1, addr: parent_of(in_idx)};
                           state_in = ST_UP_CMP;
                        end
                     end
                  end
                  CMD_END: begin
                     if (active_ff != '0) begin
                        active_in = active_ff - 1'b1;
                        state_in  = ST_POP_CHK;
                     end
                  end
                  default: ;
               endcase
            end
         end

         // The new record travels up as a hole; parents move down into it.
         ST_UP_CMP: begin
            if (rec_less(rec_ff, ram_q)) begin
               ram_wr = '{en: 1'b1, addr: idx_ff, data: ram_q};
               idx_in = par;
               if (par == '0) begin
                  state_in = ST_UP_FIN;
               end else begin
                  ram_rd = '{en: 1'b1, addr: parent_of(par)};
               end
            end else begin
               ram_wr   = '{en: 1'b1, addr: idx_ff, data: rec_ff};
               state_in = ST_POP_CHK;
            end
         end

         ST_UP_FIN: begin
            ram_wr   = '{en: 1'b1, addr: idx_ff, data: rec_ff};
            state_in = ST_POP_CHK;
         end

         // A pop waits here until the result register can take the root.
         ST_POP_CHK: begin
            if (!pop_need) begin
               state_in = ST_IDLE;
            end else if (rsp_free) begin
               ram_rd   = '{en: 1'b1, addr: '0};
               size_in  = size_ff - 1'b1;
               state_in = ST_POP_ROOT;
            end
         end

         ST_POP_ROOT: begin
            pop.load = 1'b1;
            if (size_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               ram_rd   = '{en: 1'b1, addr: size_ff[IDX_W-1:0]};
               state_in = ST_POP_LAST;
            end
         end

         ST_POP_LAST: begin
            rec_in   = ram_q;
            idx_in   = '0;
            state_in = ST_DN_CHK;
         end

         ST_DN_CHK: begin
            if (lft < size_x) begin
               ram_rd   = '{en: 1'b1, addr: lft[IDX_W-1:0]};
               state_in = ST_DN_RDR;
            end else begin
               ram_wr   = '{en: 1'b1, addr: idx_ff, data: rec_ff};
               state_in = ST_IDLE;
            end
         end

         ST_DN_RDR: begin
            child_in = ram_q;
            if (rgt < size_x) begin
               ram_rd   = '{en: 1'b1, addr: rgt[IDX_W-1:0]};
               state_in = ST_DN_CMP;
            end else if (rec_less(ram_q, rec_ff)) begin
               ram_wr   = '{en: 1'b1, addr: idx_ff, data: ram_q};
               idx_in   = lft[IDX_W-1:0];
               state_in = ST_DN_CHK;
            end else begin
               ram_wr   = '{en: 1'b1, addr: idx_ff, data: rec_ff};
               state_in = ST_IDLE;
            end
         end

         // Left child is in child_ff, right child on the read port.
         ST_DN_CMP: begin
            l_less = rec_less(child_ff, rec_ff);
            if (l_less) begin
               best     = child_ff;
               best_idx = lft;
            end
            if (rec_less(ram_q, best)) begin
               best     = ram_q;
               best_idx = rgt;
            end
            if (best_idx == CHD_W'(idx_ff)) begin
               ram_wr   = '{en: 1'b1, addr: idx_ff, data: rec_ff};
               state_in = ST_IDLE;
            end else begin
               ram_wr   = '{en: 1'b1, addr: idx_ff, data: best};
               idx_in   = best_idx[IDX_W-1:0];
               state_in = ST_DN_CHK;
            end
         end

         default: state_in = ST_IDLE;
      endcase
   end

   a_idle_size: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> ((size_ff == '0) || (size_ff < active_ff)))
      else $error("heap holds a full set of heads while idle");

   a_port_clash: assert property (@(posedge clock) disable iff (reset)
      (ram_wr.en && ram_rd.en) |-> (ram_wr.addr != ram_rd.addr))
      else $error("heap store read and written at the same entry");

   a_pop_slot: assert property (@(posedge clock) disable iff (reset)
      pop.load |-> (rsp_free && $past(state_ff) == ST_POP_CHK))
      else $error("root popped while the result register is busy");

endmodule

[hw/rtl/k_way_merge_heap.sv]
// ----------------------------------------------------------------------------
// k_way_merge_heap
// Merges up to MAX_RUNS sorted runs through a min-heap of run heads.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake     Payload
//  req_if    in         valid/ready   cmd, run, key, row_id
//  rsp_if    out        valid/ready   out_key, out_row_id, refill_run
//  csr_*     in         csr_we        csr_wdata = num_runs
//
//  Start and ignored commands are handled in the idle state; a run end adds the pop check.
//  A push into an empty heap writes the root directly; else it compares with each parent in
//  turn as it rises. A pop reads the root and, unless that empties the heap, takes the last
//  entry to the top and sinks it, reading the children through the single read port of the store.
//  Reset is synchronous and empties the heap; the store itself is not cleared.
//  A pop stalls before reading the root while an earlier result is untaken.
// ----------------------------------------------------------------------------
module k_way_merge_heap
   import kwm_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [NUM_W-1:0] csr_wdata,
   kwm_req_if.sink          req_if,
   kwm_rsp_if.source        rsp_if
);

   logic [NUM_W-1:0] num_runs_ff;
   logic             rsp_valid_ff, rsp_valid_in;
   rec_type          rsp_rec_ff;
   logic             rsp_free;
   ram_wr_type       ram_wr;
   ram_rd_type       ram_rd;
   rec_type          ram_q;
   pop_type          pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         num_runs_ff <= NUM_RUNS_RST;
      end else if (csr_we) begin
         num_runs_ff <= csr_wdata;
      end
   end

   kwm_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .num_runs (num_runs_ff),
      .req      (req_if),
      .rsp_free (rsp_free),
      .ram_wr   (ram_wr),
      .ram_rd   (ram_rd),
      .ram_q    (ram_q),
      .pop      (pop)
   );

   kwm_heap_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd      (ram_rd),
      .rd_data (ram_q)
   );

   // The result register frees up in the cycle its transfer completes.
   assign rsp_free = !rsp_valid_ff || rsp_if.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pop.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop.load) begin
         rsp_rec_ff <= pop.rec;
      end
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.out_key    = out_key_of(rsp_rec_ff.key);
   assign rsp_if.out_row_id = rsp_rec_ff.row;
   assign rsp_if.refill_run = rsp_rec_ff.run;

endmodule
